// File: rtl/core/pcc_pkg.sv
// Shared types and constants for the pixel class centroid block.
package pcc_pkg;

  localparam int unsigned COORD_W    = 10;
  localparam int unsigned LABEL_W    = 8;
  localparam int unsigned CNT_W      = 21;
  localparam int unsigned SUM_W      = COORD_W + CNT_W;
  localparam int unsigned CENTER_W   = 14;
  localparam int unsigned LIM_W      = 13;
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned FRAC_BITS  = 4;
  localparam int unsigned QDEPTH     = 2;
  localparam logic [LABEL_W-1:0] TARGET_RST = LABEL_W'(1);

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [LABEL_W-1:0] pixel_label;
    logic               frame_last;
  } pix_t;

  typedef struct packed {
    logic                found;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
  } res_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0] count;
  } job_t;

endpackage

// File: rtl/core/pcc_stream_if.sv
// Valid/ready channel carrying one payload beat.
interface pcc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/pcc_accum.sv
// Front end: target class register, pixel match and frame sum accumulation.
module pcc_accum (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  pcc_stream_if.sink                       pixel_i,
  pcc_stream_if.sink                       cfg_i,
  output logic                             job_valid_o,
  output pcc_pkg::job_t                    job_o,
  input  logic                             job_ready_i
);

  localparam logic [pcc_pkg::CNT_W-1:0] CntMax = '1;
  localparam logic [pcc_pkg::LIM_W-1:0] XLim = pcc_pkg::LIM_W'(pcc_pkg::MAX_WIDTH);
  localparam logic [pcc_pkg::LIM_W-1:0] YLim = pcc_pkg::LIM_W'(pcc_pkg::MAX_HEIGHT);

  logic [pcc_pkg::LABEL_W-1:0] target_q;
  logic [pcc_pkg::SUM_W-1:0]   sum_x_q, sum_y_q, sum_x_d, sum_y_d;
  logic [pcc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                        accept, match;

  assign cfg_i.ready   = 1'b1;
  assign pixel_i.ready = job_ready_i;
  assign accept        = pixel_i.valid && pixel_i.ready;

  assign match = (pixel_i.data.pixel_label == target_q) &&
                 (pcc_pkg::LIM_W'(pixel_i.data.pixel_x) < XLim) &&
                 (pcc_pkg::LIM_W'(pixel_i.data.pixel_y) < YLim) &&
                 (cnt_q != CntMax);

  always_comb begin
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    cnt_d   = cnt_q;
    if (match) begin
      sum_x_d = sum_x_q + pcc_pkg::SUM_W'(pixel_i.data.pixel_x);
      sum_y_d = sum_y_q + pcc_pkg::SUM_W'(pixel_i.data.pixel_y);
      cnt_d   = cnt_q + pcc_pkg::CNT_W'(1);
    end
  end

  assign job_valid_o = accept && pixel_i.data.frame_last;
  assign job_o       = '{sum_x: sum_x_d, sum_y: sum_y_d, count: cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= pcc_pkg::TARGET_RST;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        target_q <= cfg_i.data;
      end
      if (accept) begin
        if (pixel_i.data.frame_last) begin
          sum_x_q <= '0;
          sum_y_q <= '0;
          cnt_q   <= '0;
        end else begin
          sum_x_q <= sum_x_d;
          sum_y_q <= sum_y_d;
          cnt_q   <= cnt_d;
        end
      end
    end
  end

endmodule

// File: rtl/core/pcc_queue.sv
// Short FIFO of finished frame sums between front end and divider.
module pcc_queue #(
  parameter int unsigned DEPTH = pcc_pkg::QDEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pcc_pkg::job_t push_data_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output pcc_pkg::job_t pop_data_o,
  input  logic          pop_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  pcc_pkg::job_t       mem_q [DEPTH];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     fill_q;
  logic                do_push, do_pop;

  assign push_ready_o = (fill_q != CntW'(DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      fill_q <= fill_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

// File: rtl/core/pcc_divider.sv
// Back end: bit-serial centroid division for x and y, result register.
module pcc_divider #(
  parameter int unsigned FRAC_BITS = pcc_pkg::FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  pcc_pkg::job_t job_i,
  output logic          job_pop_o,
  pcc_stream_if.source  result_o
);

  localparam int unsigned DW    = pcc_pkg::SUM_W + FRAC_BITS;
  localparam int unsigned QW    = pcc_pkg::COORD_W + FRAC_BITS;
  localparam int unsigned RW    = pcc_pkg::CNT_W;
  localparam int unsigned StepW = $clog2(QW + 1);
  localparam int unsigned ExtW  = QW + pcc_pkg::CENTER_W;
  localparam logic [ExtW-1:0] CenterMax = ExtW'({pcc_pkg::CENTER_W{1'b1}});

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [StepW-1:0]    step_q;
  logic [RW-1:0]       div_q, rem_x_q, rem_y_q, rem_x_d, rem_y_d;
  logic [QW-1:0]       lo_x_q, lo_y_q;
  logic                bit_x, bit_y;
  logic [RW:0]         trial_x, trial_y;
  logic [DW-1:0]       dvd_x, dvd_y;
  logic [ExtW-1:0]     q_x_ext, q_y_ext;
  logic                out_free;
  pcc_pkg::res_t       res_q;
  logic                res_valid_q;

  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;
  assign out_free       = !res_valid_q || result_o.ready;
  assign job_pop_o      = (state_q == ST_IDLE) && job_valid_i;

  assign dvd_x = DW'(job_i.sum_x) << FRAC_BITS;
  assign dvd_y = DW'(job_i.sum_y) << FRAC_BITS;

  assign trial_x = {rem_x_q, lo_x_q[QW-1]};
  assign trial_y = {rem_y_q, lo_y_q[QW-1]};
  assign bit_x   = (trial_x >= {1'b0, div_q});
  assign bit_y   = (trial_y >= {1'b0, div_q});
  assign rem_x_d = bit_x ? RW'(trial_x - {1'b0, div_q}) : RW'(trial_x);
  assign rem_y_d = bit_y ? RW'(trial_y - {1'b0, div_q}) : RW'(trial_y);

  assign q_x_ext = ExtW'(lo_x_q);
  assign q_y_ext = ExtW'(lo_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      div_q       <= '0;
      rem_x_q     <= '0;
      rem_y_q     <= '0;
      lo_x_q      <= '0;
      lo_y_q      <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_DONE) && out_free) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && result_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            div_q   <= job_i.count;
            rem_x_q <= dvd_x[DW-1:QW];
            rem_y_q <= dvd_y[DW-1:QW];
            lo_x_q  <= dvd_x[QW-1:0];
            lo_y_q  <= dvd_y[QW-1:0];
            step_q  <= StepW'(QW);
            state_q <= (job_i.count == '0) ? ST_DONE : ST_DIV;
          end
        end
        ST_DIV: begin
          rem_x_q <= rem_x_d;
          rem_y_q <= rem_y_d;
          lo_x_q  <= {lo_x_q[QW-2:0], bit_x};
          lo_y_q  <= {lo_y_q[QW-2:0], bit_y};
          step_q  <= step_q - StepW'(1);
          if (step_q == StepW'(1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            res_q.found <= (div_q != '0);
            if (div_q == '0) begin
              res_q.center_x <= '0;
              res_q.center_y <= '0;
            end else begin
              res_q.center_x <= (q_x_ext > CenterMax) ? CenterMax[pcc_pkg::CENTER_W-1:0]
                                                      : q_x_ext[pcc_pkg::CENTER_W-1:0];
              res_q.center_y <= (q_y_ext > CenterMax) ? CenterMax[pcc_pkg::CENTER_W-1:0]
                                                      : q_y_ext[pcc_pkg::CENTER_W-1:0];
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/pixel_class_centroid_top.sv
// Top level of the pixel class centroid block.
//
// Channels: pixel_i takes one pixel beat (x, y, label, last flag); result_o
// gives one beat per frame (found, center_x, center_y, unsigned with
// FRAC_BITS fraction bits, truncated); cfg_i writes the target class label.
// The front end takes one pixel per cycle while the queue has room and
// sums matching coordinates. On the last pixel of a frame the sums go
// into a two-entry queue, so the next frame keeps streaming while the
// divider works. The divider is a restoring bit-serial unit, one quotient
// bit per cycle for x and y together; each quotient is COORD_W + FRAC_BITS
// bits wide. A frame with no match skips the division. The divider takes
// the next frame's sums only once it is back in its idle state.
// Reset clears the sums, the queue and the result register, and sets the
// target class to 1. When result_o stalls the held result waits, the
// queue fills, and pixel_i drops ready only once the queue is full.
module pixel_class_centroid_top #(
  parameter int unsigned FRAC_BITS = pcc_pkg::FRAC_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcc_stream_if.sink   pixel_i,
  pcc_stream_if.sink   cfg_i,
  pcc_stream_if.source result_o
);

  logic          push, push_ready, pop_valid, pop;
  pcc_pkg::job_t push_data, pop_data;

  pcc_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pixel_i     (pixel_i),
    .cfg_i       (cfg_i),
    .job_valid_o (push),
    .job_o       (push_data),
    .job_ready_i (push_ready)
  );

  pcc_queue #(
    .DEPTH (pcc_pkg::QDEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_i        (pop)
  );

  pcc_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_i       (pop_data),
    .job_pop_o   (pop),
    .result_o    (result_o)
  );

endmodule
